FILE: design/pttr_pkg.sv
// Shared types and constants for the potentiometer taper resistance block.
// Used by pttr_taper and potentiometer_taper_resistance; no dependencies.
`default_nettype none

package pttr_pkg;

    localparam int POS_FRAC_BITS_DEF = 16;
    localparam int OHM_BITS_DEF      = 36;
    localparam int SLOT_BITS_DEF     = 8;

    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TAPER_MODE = 3'd0,
        CFG_MAX_OHMS   = 3'd1,
        CFG_MIN_OHMS   = 3'd2,
        CFG_UPPER_SLOT = 3'd3,
        CFG_LOWER_SLOT = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        TAPER_LINEAR   = 3'd0,
        TAPER_LOG      = 3'd1,
        TAPER_REV_LOG  = 3'd2,
        TAPER_AUDIO_05 = 3'd3,
        TAPER_AUDIO_10 = 3'd4,
        TAPER_AUDIO_15 = 3'd5,
        TAPER_AUDIO_20 = 3'd6,
        TAPER_AUDIO_30 = 3'd7
    } taper_mode_t;

    localparam longint unsigned MAX_OHMS_RESET = 64'd10000000;

    // audio taper track fraction at half rotation, per mille
    localparam int unsigned PERMILLE_05 = 50;
    localparam int unsigned PERMILLE_10 = 100;
    localparam int unsigned PERMILLE_15 = 150;
    localparam int unsigned PERMILLE_20 = 200;
    localparam int unsigned PERMILLE_30 = 300;

    // round(permille / 1000 * 2^frac_bits), elaboration only
    function automatic longint unsigned audio_mid(input int unsigned permille,
                                                  input int unsigned frac_bits);
        longint unsigned scaled;
        scaled = 64'(permille) << frac_bits;
        return (scaled + 64'd500) / 64'd1000;
    endfunction

endpackage

`default_nettype wire

FILE: design/potentiometer_taper_resistance.sv
// Top level of the potentiometer taper resistance block: config registers,
// leg scaling pipeline and output register. Depends on pttr_pkg, pttr_taper.
//
//   channel   signals                                   direction
//   s_        s_valid s_ready s_position                in
//   m_        m_valid m_ready m_upper_* m_lower_*       out
//   cfg_      cfg_we cfg_index cfg_wdata                in (write only)
//
// Six register stages: three in the taper curve (clamp/select, multiply,
// round), then complement, leg multiply, round/floor into the output register.
// One transaction per cycle when the output is not stalled.
// Synchronous active-low reset empties the pipeline and loads register defaults.
// A stall on m_ready backs up stage by stage; nothing is dropped or repeated.
`default_nettype none

module potentiometer_taper_resistance #(
    parameter int POS_FRAC_BITS = pttr_pkg::POS_FRAC_BITS_DEF,
    parameter int OHM_BITS      = pttr_pkg::OHM_BITS_DEF,
    parameter int SLOT_BITS     = pttr_pkg::SLOT_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,

    input  wire logic                            cfg_we,
    input  wire logic [pttr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [((OHM_BITS > SLOT_BITS + 1) ? OHM_BITS : SLOT_BITS + 1)-1:0] cfg_wdata,

    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic signed [POS_FRAC_BITS+1:0] s_position,

    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_upper_write,
    output logic [SLOT_BITS-1:0]                 m_upper_index,
    output logic [OHM_BITS-1:0]                  m_upper_ohms,
    output logic                                 m_lower_write,
    output logic [SLOT_BITS-1:0]                 m_lower_index,
    output logic [OHM_BITS-1:0]                  m_lower_ohms
);

    localparam int F    = POS_FRAC_BITS;
    localparam int HI_W = (OHM_BITS > F) ? OHM_BITS - F : 1;
    localparam int RX_W = HI_W + F;
    localparam int HP_W = HI_W + F + 1;
    localparam int LP_W = 2 * F + 1;
    localparam int TW   = HI_W + F + 3;

    localparam logic [F:0]    ONE = (F + 1)'(1) << F;
    localparam logic [LP_W:0] RND = (LP_W + 1)'(1) << (F - 1);

    // configuration registers
    pttr_pkg::taper_mode_t taper_mode_reg;
    logic [OHM_BITS-1:0]   max_ohms_reg;
    logic [OHM_BITS-1:0]   min_ohms_reg;
    logic [SLOT_BITS:0]    upper_slot_reg;
    logic [SLOT_BITS:0]    lower_slot_reg;

    // per-leg setup, follows the config registers in the next cycle
    logic                  up_wr_reg, up_wr_next;
    logic                  lo_wr_reg, lo_wr_next;
    logic [SLOT_BITS-1:0]  up_idx_reg, up_idx_next;
    logic [SLOT_BITS-1:0]  lo_idx_reg, lo_idx_next;
    logic [OHM_BITS-1:0]   up_span_reg, up_span_next;
    logic [OHM_BITS-1:0]   lo_span_reg, lo_span_next;
    logic [OHM_BITS-1:0]   up_base_reg, up_base_next;
    logic [OHM_BITS-1:0]   lo_base_reg, lo_base_next;
    logic [OHM_BITS-1:0]   rheo_span;

    logic                  tap_valid, tap_ready;
    logic [F:0]            tap_n;

    logic                  v1_reg, v2_reg, v3_reg;
    logic                  rdy1, rdy2, rdy3;

    logic [F:0]            nu_reg, nl_reg;
    logic [RX_W-1:0]       up_rx, lo_rx;
    logic [HP_W-1:0]       hpu_reg, hpu_next, hpl_reg, hpl_next;
    logic [LP_W-1:0]       lpu_reg, lpu_next, lpl_reg, lpl_next;

    logic [LP_W:0]         rsum_u, rsum_l;
    logic [TW-1:0]         tot_u, tot_l;
    logic [OHM_BITS-1:0]   up_ohms_reg, up_ohms_next;
    logic [OHM_BITS-1:0]   lo_ohms_reg, lo_ohms_next;
    logic                  out_up_wr_reg, out_lo_wr_reg;
    logic [SLOT_BITS-1:0]  out_up_idx_reg, out_lo_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            taper_mode_reg <= pttr_pkg::TAPER_LINEAR;
            max_ohms_reg   <= OHM_BITS'(pttr_pkg::MAX_OHMS_RESET);
            min_ohms_reg   <= '0;
            upper_slot_reg <= '1;
            lower_slot_reg <= '1;
        end else if (cfg_we) begin
            case (cfg_index)
                pttr_pkg::CFG_TAPER_MODE: begin
                    taper_mode_reg <= pttr_pkg::taper_mode_t'(cfg_wdata[2:0]);
                end
                pttr_pkg::CFG_MAX_OHMS:   max_ohms_reg   <= cfg_wdata[OHM_BITS-1:0];
                pttr_pkg::CFG_MIN_OHMS:   min_ohms_reg   <= cfg_wdata[OHM_BITS-1:0];
                pttr_pkg::CFG_UPPER_SLOT: upper_slot_reg <= cfg_wdata[SLOT_BITS:0];
                pttr_pkg::CFG_LOWER_SLOT: lower_slot_reg <= cfg_wdata[SLOT_BITS:0];
                default: ;
            endcase
        end
    end

    // wiring: both legs form a divider, one leg alone is a rheostat
    always_comb begin
        up_wr_next   = !upper_slot_reg[SLOT_BITS];
        lo_wr_next   = !lower_slot_reg[SLOT_BITS];
        up_idx_next  = up_wr_next ? upper_slot_reg[SLOT_BITS-1:0] : '0;
        lo_idx_next  = lo_wr_next ? lower_slot_reg[SLOT_BITS-1:0] : '0;
        rheo_span    = (max_ohms_reg > min_ohms_reg) ? max_ohms_reg - min_ohms_reg : '0;
        if (up_wr_next && lo_wr_next) begin
            up_span_next = max_ohms_reg;
            lo_span_next = max_ohms_reg;
            up_base_next = '0;
            lo_base_next = '0;
        end else begin
            up_span_next = rheo_span;
            lo_span_next = rheo_span;
            up_base_next = min_ohms_reg;
            lo_base_next = min_ohms_reg;
        end
    end

    always_ff @(posedge aclk) begin
        up_wr_reg   <= up_wr_next;
        lo_wr_reg   <= lo_wr_next;
        up_idx_reg  <= up_idx_next;
        lo_idx_reg  <= lo_idx_next;
        up_span_reg <= up_span_next;
        lo_span_reg <= lo_span_next;
        up_base_reg <= up_base_next;
        lo_base_reg <= lo_base_next;
    end

    pttr_taper #(
        .POS_FRAC_BITS (POS_FRAC_BITS)
    ) u_taper (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_position (s_position),
        .mode        (taper_mode_reg),
        .out_valid   (tap_valid),
        .out_ready   (tap_ready),
        .out_n       (tap_n)
    );

    assign rdy3      = !v3_reg || m_ready;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign tap_ready = rdy1;

    // span split into high and low parts so each product stays narrow
    assign up_rx    = RX_W'(up_span_reg);
    assign lo_rx    = RX_W'(lo_span_reg);
    assign hpu_next = HP_W'(up_rx[RX_W-1:F]) * HP_W'(nu_reg);
    assign lpu_next = LP_W'(up_rx[F-1:0]) * LP_W'(nu_reg);
    assign hpl_next = HP_W'(lo_rx[RX_W-1:F]) * HP_W'(nl_reg);
    assign lpl_next = LP_W'(lo_rx[F-1:0]) * LP_W'(nl_reg);

    // base + round(span * n), floored at min_ohms, above max_ohms only if min_ohms is; zero for an unwritten leg
    always_comb begin
        rsum_u = (LP_W + 1)'(lpu_reg) + RND;
        rsum_l = (LP_W + 1)'(lpl_reg) + RND;
        tot_u  = TW'(up_base_reg) + TW'(hpu_reg) + TW'(rsum_u[LP_W:F]);
        tot_l  = TW'(lo_base_reg) + TW'(hpl_reg) + TW'(rsum_l[LP_W:F]);
        if (!up_wr_reg) begin
            up_ohms_next = '0;
        end else if (tot_u > TW'(min_ohms_reg)) begin
            up_ohms_next = tot_u[OHM_BITS-1:0];
        end else begin
            up_ohms_next = min_ohms_reg;
        end
        if (!lo_wr_reg) begin
            lo_ohms_next = '0;
        end else if (tot_l > TW'(min_ohms_reg)) begin
            lo_ohms_next = tot_l[OHM_BITS-1:0];
        end else begin
            lo_ohms_next = min_ohms_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= tap_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && tap_valid) begin
            nu_reg <= ONE - tap_n;
            nl_reg <= tap_n;
        end
        if (rdy2 && v1_reg) begin
            hpu_reg <= hpu_next;
            lpu_reg <= lpu_next;
            hpl_reg <= hpl_next;
            lpl_reg <= lpl_next;
        end
        if (rdy3 && v2_reg) begin
            up_ohms_reg    <= up_ohms_next;
            lo_ohms_reg    <= lo_ohms_next;
            out_up_wr_reg  <= up_wr_reg;
            out_lo_wr_reg  <= lo_wr_reg;
            out_up_idx_reg <= up_idx_reg;
            out_lo_idx_reg <= lo_idx_reg;
        end
    end

    assign m_valid       = v3_reg;
    assign m_upper_write = out_up_wr_reg;
    assign m_upper_index = out_up_idx_reg;
    assign m_upper_ohms  = up_ohms_reg;
    assign m_lower_write = out_lo_wr_reg;
    assign m_lower_index = out_lo_idx_reg;
    assign m_lower_ohms  = lo_ohms_reg;

    // a leg that is not written carries all zero fields
    a_upper_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_upper_write |-> m_upper_ohms == '0 && m_upper_index == '0)
        else $error("upper leg not written but fields nonzero");

    a_lower_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_lower_write |-> m_lower_ohms == '0 && m_lower_index == '0)
        else $error("lower leg not written but fields nonzero");

    // tapered fraction never exceeds full scale
    a_taper_range: assert property (@(posedge aclk) disable iff (!aresetn)
        tap_valid |-> tap_n <= ONE)
        else $error("taper output above one");

    // backpressure reaches the input only when every leg stage is full
    a_full_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> v1_reg && v2_reg && v3_reg && !m_ready)
        else $error("input stalled with a bubble in the pipeline");

endmodule

`default_nettype wire

FILE: design/pttr_taper.sv
// Three-stage taper curve pipeline: clamp and operand select, multiply, round.
// Depends on pttr_pkg.
`default_nettype none

module pttr_taper #(
    parameter int POS_FRAC_BITS = pttr_pkg::POS_FRAC_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic signed [POS_FRAC_BITS+1:0] in_position,
    input  wire pttr_pkg::taper_mode_t       mode,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [POS_FRAC_BITS:0]           out_n
);

    localparam int F  = POS_FRAC_BITS;
    localparam int PW = 2 * F + 2;

    localparam logic [F:0]    ONE      = (F + 1)'(1) << F;
    localparam logic [F:0]    HALF_ONE = (F + 1)'(1) << (F - 1);
    localparam logic [PW:0]   RND      = (PW + 1)'(1) << (F - 1);

    localparam logic [F:0] MID_05 = (F + 1)'(pttr_pkg::audio_mid(pttr_pkg::PERMILLE_05, F));
    localparam logic [F:0] MID_10 = (F + 1)'(pttr_pkg::audio_mid(pttr_pkg::PERMILLE_10, F));
    localparam logic [F:0] MID_15 = (F + 1)'(pttr_pkg::audio_mid(pttr_pkg::PERMILLE_15, F));
    localparam logic [F:0] MID_20 = (F + 1)'(pttr_pkg::audio_mid(pttr_pkg::PERMILLE_20, F));
    localparam logic [F:0] MID_30 = (F + 1)'(pttr_pkg::audio_mid(pttr_pkg::PERMILLE_30, F));

    // slopes of the two audio segments, Q1.F
    localparam logic [F:0] RISE_05 = MID_05 << 1;
    localparam logic [F:0] RISE_10 = MID_10 << 1;
    localparam logic [F:0] RISE_15 = MID_15 << 1;
    localparam logic [F:0] RISE_20 = MID_20 << 1;
    localparam logic [F:0] RISE_30 = MID_30 << 1;
    localparam logic [F:0] FALL_05 = (ONE - MID_05) << 1;
    localparam logic [F:0] FALL_10 = (ONE - MID_10) << 1;
    localparam logic [F:0] FALL_15 = (ONE - MID_15) << 1;
    localparam logic [F:0] FALL_20 = (ONE - MID_20) << 1;
    localparam logic [F:0] FALL_30 = (ONE - MID_30) << 1;

    logic          s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic          rdy1, rdy2, rdy3;

    logic [F:0]    s1_a_reg, s1_a_next;
    logic [F:0]    s1_b_reg, s1_b_next;
    logic [F:0]    s1_base_reg, s1_base_next;
    logic          s1_inv_reg, s1_inv_next;

    logic [PW-1:0] s2_prod_reg, s2_prod_next;
    logic [F:0]    s2_base_reg;
    logic          s2_inv_reg;

    logic [F:0]    s3_n_reg, s3_n_next;

    logic [F:0]    p;
    logic [F:0]    mid, rise, fall;
    logic [PW:0]   rsum;
    logic [F+2:0]  q, t;

    assign rdy3     = !s3_valid_reg || out_ready;
    assign rdy2     = !s2_valid_reg || rdy3;
    assign rdy1     = !s1_valid_reg || rdy2;
    assign in_ready = rdy1;

    // stage 1: clamp to 0..1 and pick multiplier operands for the curve
    always_comb begin
        if (in_position[F+1]) begin
            p = '0;
        end else if (in_position[F] && (|in_position[F-1:0])) begin
            p = ONE;
        end else begin
            p = in_position[F:0];
        end

        case (mode)
            pttr_pkg::TAPER_AUDIO_05: begin mid = MID_05; rise = RISE_05; fall = FALL_05; end
            pttr_pkg::TAPER_AUDIO_10: begin mid = MID_10; rise = RISE_10; fall = FALL_10; end
            pttr_pkg::TAPER_AUDIO_15: begin mid = MID_15; rise = RISE_15; fall = FALL_15; end
            pttr_pkg::TAPER_AUDIO_20: begin mid = MID_20; rise = RISE_20; fall = FALL_20; end
            default:                  begin mid = MID_30; rise = RISE_30; fall = FALL_30; end
        endcase

        s1_base_next = '0;
        s1_inv_next  = 1'b0;
        case (mode)
            pttr_pkg::TAPER_LINEAR: begin
                // p * 1.0 rounds back to p
                s1_a_next = p;
                s1_b_next = ONE;
            end
            pttr_pkg::TAPER_LOG: begin
                s1_a_next = p;
                s1_b_next = p;
            end
            pttr_pkg::TAPER_REV_LOG: begin
                s1_a_next   = ONE - p;
                s1_b_next   = ONE - p;
                s1_inv_next = 1'b1;
            end
            default: begin
                if (p <= HALF_ONE) begin
                    s1_a_next = rise;
                    s1_b_next = p;
                end else begin
                    s1_a_next    = fall;
                    s1_b_next    = p - HALF_ONE;
                    s1_base_next = mid;
                end
            end
        endcase
    end

    // stage 2: product
    assign s2_prod_next = PW'(s1_a_reg) * PW'(s1_b_reg);

    // stage 3: round half up, add segment base or reflect, clamp to 1
    always_comb begin
        rsum = (PW + 1)'(s2_prod_reg) + RND;
        q    = rsum[PW:F];
        if (s2_inv_reg) begin
            t = (F + 3)'(ONE) - q;
        end else begin
            t = (F + 3)'(s2_base_reg) + q;
        end
        s3_n_next = (t > (F + 3)'(ONE)) ? ONE : t[F:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                s1_valid_reg <= in_valid;
            end
            if (rdy2) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rdy3) begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            s1_a_reg    <= s1_a_next;
            s1_b_reg    <= s1_b_next;
            s1_base_reg <= s1_base_next;
            s1_inv_reg  <= s1_inv_next;
        end
        if (rdy2 && s1_valid_reg) begin
            s2_prod_reg <= s2_prod_next;
            s2_base_reg <= s1_base_reg;
            s2_inv_reg  <= s1_inv_reg;
        end
        if (rdy3 && s2_valid_reg) begin
            s3_n_reg <= s3_n_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_n     = s3_n_reg;

endmodule

`default_nettype wire
